// ----- rtl/epd_pkg.sv -----
// Shared types and constants of the escaped path decoder.
// No dependencies; the RTL and testbench files other than epd_if.sv refer to it by scoped names.
package epd_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_OCTAL  = 2'd2
  } mode_e;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChLetterN   = 8'h6E;
  localparam logic [7:0] ChLetterR   = 8'h72;
  localparam logic [7:0] ChLetterT   = 8'h74;
  localparam logic [7:0] ChLetterB   = 8'h62;
  localparam logic [7:0] ChLetterF   = 8'h66;
  localparam logic [7:0] ChLetterV   = 8'h76;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChBs        = 8'h08;
  localparam logic [7:0] ChFf        = 8'h0C;
  localparam logic [7:0] ChVt        = 8'h0B;

  localparam logic [1:0] OctalLastDigit = 2'd2;

  // One result beat before the last flag is attached.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       path_end;
  } result_t;

  // Work for the back end: one or two result beats.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } cmd_t;

  // Outcome of handling a byte in normal mode.
  typedef struct packed {
    logic    emit;
    logic    esc;
    result_t res;
  } plain_t;

endpackage

// ----- rtl/epd_if.sv -----
// Handshake channels of the escaped path decoder: raw bytes in, decoded beats out.
// No dependencies.
interface epd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface epd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       path_end;
  logic       last;

  modport source (output valid, output out_byte, output path_end, output last, input ready);
  modport sink (input valid, input out_byte, input path_end, input last, output ready);
endinterface

// ----- rtl/epd_front.sv -----
// Front end: accepts raw bytes, tracks escape and octal state, issues commands.
// Depends on epd_pkg and epd_in_if.
module epd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  epd_in_if.sink              in_i,
  input  logic                q_full_i,
  output logic                push_o,
  output epd_pkg::cmd_t       cmd_o
);

  epd_pkg::mode_e mode_q, mode_d;
  logic [7:0]     accum_q, accum_d;
  logic [1:0]     digits_q, digits_d;
  logic [1:0]     cnt;
  logic           accept;
  logic [7:0]     b;
  logic           eoi;
  logic           is_oct;
  logic [8:0]     esc_hit;
  epd_pkg::plain_t pl;

  function automatic epd_pkg::plain_t plain(input logic [7:0] v, input logic e);
    epd_pkg::plain_t p;
    p = '0;
    if (e || v == epd_pkg::ChSpace || (v >= epd_pkg::ChTab && v <= epd_pkg::ChCr)) begin
      p.emit = 1'b1;
      p.res.path_end = 1'b1;
    end else if (v == epd_pkg::ChBackslash) begin
      p.esc = 1'b1;
    end else begin
      p.emit = 1'b1;
      p.res.out_byte = v;
    end
    return p;
  endfunction

  // Known escape letters: {hit, decoded byte}
  function automatic logic [8:0] esc_map(input logic [7:0] v);
    logic [8:0] r;
    case (v)
      epd_pkg::ChBackslash: r = {1'b1, epd_pkg::ChBackslash};
      epd_pkg::ChSpace:     r = {1'b1, epd_pkg::ChSpace};
      epd_pkg::ChLetterN:   r = {1'b1, epd_pkg::ChLf};
      epd_pkg::ChLetterR:   r = {1'b1, epd_pkg::ChCr};
      epd_pkg::ChLetterT:   r = {1'b1, epd_pkg::ChTab};
      epd_pkg::ChLetterB:   r = {1'b1, epd_pkg::ChBs};
      epd_pkg::ChLetterF:   r = {1'b1, epd_pkg::ChFf};
      epd_pkg::ChLetterV:   r = {1'b1, epd_pkg::ChVt};
      default:              r = 9'd0;
    endcase
    return r;
  endfunction

  assign in_i.ready = ~q_full_i;
  assign accept     = in_i.valid & ~q_full_i;
  assign b          = in_i.in_byte;
  assign eoi        = in_i.end_of_input;
  assign is_oct     = (b >= epd_pkg::ChZero) && (b <= epd_pkg::ChSeven);
  assign esc_hit    = esc_map(b);
  assign pl         = plain(b, eoi);

  always_comb begin
    mode_d   = mode_q;
    accum_d  = accum_q;
    digits_d = digits_q;
    cnt      = 2'd0;
    cmd_o    = '0;
    case (mode_q)
      epd_pkg::MODE_ESCAPE: begin
        mode_d = epd_pkg::MODE_NORMAL;
        if (!eoi && esc_hit[8]) begin
          cmd_o.r0.out_byte = esc_hit[7:0];
          cnt = 2'd1;
        end else if (!eoi && is_oct) begin
          mode_d   = epd_pkg::MODE_OCTAL;
          accum_d  = {5'd0, b[2:0]};
          digits_d = 2'd1;
        end else begin
          // unknown escape or end of input: zero byte, then handle the byte as ordinary
          cmd_o.r1 = pl.res;
          if (pl.esc) begin
            mode_d = epd_pkg::MODE_ESCAPE;
            cnt = 2'd1;
          end else begin
            cnt = 2'd2;
          end
        end
      end
      epd_pkg::MODE_OCTAL: begin
        if (!eoi && is_oct) begin
          accum_d = {accum_q[4:0], b[2:0]};
          if (digits_q == epd_pkg::OctalLastDigit) begin
            cmd_o.r0.out_byte = accum_d;
            cnt      = 2'd1;
            mode_d   = epd_pkg::MODE_NORMAL;
            accum_d  = '0;
            digits_d = '0;
          end else begin
            digits_d = digits_q + 2'd1;
          end
        end else begin
          cmd_o.r0.out_byte = accum_q;
          cmd_o.r1 = pl.res;
          accum_d  = '0;
          digits_d = '0;
          if (pl.esc) begin
            mode_d = epd_pkg::MODE_ESCAPE;
            cnt = 2'd1;
          end else begin
            mode_d = epd_pkg::MODE_NORMAL;
            cnt = 2'd2;
          end
        end
      end
      default: begin
        mode_d   = pl.esc ? epd_pkg::MODE_ESCAPE : epd_pkg::MODE_NORMAL;
        cmd_o.r0 = pl.res;
        cnt      = {1'b0, pl.emit};
      end
    endcase
    cmd_o.two = (cnt == 2'd2);
  end

  assign push_o = accept & (cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= epd_pkg::MODE_NORMAL;
      accum_q  <= '0;
      digits_q <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      accum_q  <= accum_d;
      digits_q <= digits_d;
    end
  end

  a_digits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_q != 2'd3)
    else $error("octal digit count out of range");
  a_digits_only_in_octal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != epd_pkg::MODE_OCTAL |-> digits_q == 2'd0 && accum_q == 8'd0)
    else $error("octal state left behind outside octal mode");

endmodule

// ----- rtl/epd_queue.sv -----
// Short command queue between the front and back ends, held in flip-flops.
// Depends on epd_pkg.
module epd_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  epd_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output epd_pkg::cmd_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  epd_pkg::cmd_t   mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   count_q;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= bump(wr_q);
      end
      if (pop_i) begin
        rd_q <= bump(rd_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

// ----- rtl/epd_back.sv -----
// Back end: plays out each queued command as one or two output beats.
// Depends on epd_pkg and epd_out_if.
module epd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  epd_pkg::cmd_t head_i,
  output logic          pop_o,
  epd_out_if.source     out_o
);

  logic    idx_q, idx_d;
  logic    fire;
  epd_pkg::result_t cur;

  assign cur            = idx_q ? head_i.r1 : head_i.r0;
  assign out_o.valid    = ~empty_i;
  assign out_o.out_byte = cur.out_byte;
  assign out_o.path_end = cur.path_end;
  assign out_o.last     = ~head_i.two | idx_q;
  assign fire           = out_o.valid & out_o.ready;
  assign pop_o          = fire & out_o.last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = ~out_o.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_second_beat_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q |-> !empty_i && head_i.two)
    else $error("second beat without a two-beat command");

endmodule

// ----- rtl/escaped_path_decoder.sv -----
// Escaped path decoder. Takes one raw byte (or an end-of-input mark) per input beat and
// returns the decoded bytes of whitespace-separated paths, each path closed by a beat with
// path_end set; last marks the final beat caused by an input. A new input is accepted every
// cycle while the command queue (QueueDepth entries) has room: every result of an input takes
// its own output beat, so the output port sets the sustained rate. The escape state is updated
// in the same cycle the byte is taken, and the first result of an input can leave on the
// cycle after it was accepted.
module escaped_path_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  epd_in_if.sink    in_i,
  epd_out_if.source out_o
);

  logic          push, pop, full, empty;
  epd_pkg::cmd_t cmd, head;

  epd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (full),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  epd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  epd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ----- dv/tb_escaped_path_decoder.sv -----
// Testbench for the escaped path decoder: directed table, then random escaped text
// under several idle and stall patterns; beats checked by a local decoder or typed rows.
// Depends on epd_pkg, the epd_in_if / epd_out_if interfaces and escaped_path_decoder.
`timescale 1ns / 1ps

module tb_escaped_path_decoder;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       path_end;
    logic       last;
  } beat_t;

  // One input beat; typed rows carry their own expected beats.
  typedef struct packed {
    logic [7:0] raw;
    logic       eoi;
    logic       typed;
    logic [1:0] n;
    beat_t      b0;
    beat_t      b1;
  } row_t;

  localparam beat_t NoBeat   = '0;
  localparam beat_t TermBeat = '{8'h00, 1'b1, 1'b1};
  localparam beat_t ZeroData = '{8'h00, 1'b0, 1'b0};
  localparam logic [1:0] OctalMaxDigits = 2'd3;
  localparam int DirCount    = 27;
  localparam int PhaseItems  = 450;
  localparam int DrainCycles = 16;
  localparam int CycleLimit  = 200000;

  localparam logic [7:0] EscLetters [8] = '{
    epd_pkg::ChBackslash, epd_pkg::ChSpace, epd_pkg::ChLetterN, epd_pkg::ChLetterR,
    epd_pkg::ChLetterT, epd_pkg::ChLetterB, epd_pkg::ChLetterF, epd_pkg::ChLetterV
  };

  localparam row_t DirRows [DirCount] = '{
    '{8'h61, 1'b0, 1'b1, 2'd1, '{8'h61, 1'b0, 1'b1}, NoBeat},
    '{8'h00, 1'b0, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1}, NoBeat},
    '{8'hFF, 1'b0, 1'b1, 2'd1, '{8'hFF, 1'b0, 1'b1}, NoBeat},
    '{epd_pkg::ChSpace, 1'b0, 1'b1, 2'd1, TermBeat, NoBeat},
    '{epd_pkg::ChCr, 1'b0, 1'b1, 2'd1, TermBeat, NoBeat},
    '{8'hA5, 1'b1, 1'b1, 2'd1, TermBeat, NoBeat},       // end mark, byte ignored
    '{epd_pkg::ChBackslash, 1'b0, 1'b1, 2'd0, NoBeat, NoBeat},
    '{epd_pkg::ChLetterN, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{epd_pkg::ChBackslash, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{epd_pkg::ChBackslash, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{epd_pkg::ChBackslash, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{epd_pkg::ChLf, 1'b0, 1'b1, 2'd2, ZeroData, TermBeat},      // backslash before newline
    '{epd_pkg::ChBackslash, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{epd_pkg::ChSeven, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{epd_pkg::ChSeven, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{epd_pkg::ChSeven, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},       // three digits, truncated
    '{epd_pkg::ChBackslash, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{8'h34, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{8'h78, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},         // short octal run
    '{epd_pkg::ChBackslash, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{8'h31, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{8'h32, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{8'h00, 1'b1, 1'b0, 2'd0, NoBeat, NoBeat},         // end inside an octal run
    '{epd_pkg::ChBackslash, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{8'h5A, 1'b1, 1'b1, 2'd2, ZeroData, TermBeat},     // end right after a backslash
    '{epd_pkg::ChBackslash, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
    '{8'h71, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat}          // unknown escape
  };

  logic clk_i;
  logic rst_ni;

  epd_in_if  in_ch ();
  epd_out_if out_ch ();

  escaped_path_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Local decoder state
  epd_pkg::mode_e dec_mode  = epd_pkg::MODE_NORMAL;
  logic [7:0]     octal_val = 8'h00;
  logic [1:0]     octal_cnt = 2'd0;

  beat_t decoded_q [$];
  beat_t step_beats [$];
  row_t  pending_q [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int n_items   = 0;
  int n_beats   = 0;
  int n_ends    = 0;
  int cycles    = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic is_blank(logic [7:0] raw);
    return raw == epd_pkg::ChSpace || (raw >= epd_pkg::ChTab && raw <= epd_pkg::ChCr);
  endfunction

  function automatic logic is_octal(logic [7:0] raw);
    return raw >= epd_pkg::ChZero && raw <= epd_pkg::ChSeven;
  endfunction

  function automatic void emit_beat(logic [7:0] value, logic term);
    step_beats.push_back('{term ? 8'h00 : value, term, 1'b0});
  endfunction

  function automatic void decode_plain(logic [7:0] raw, logic eoi);
    if (eoi || is_blank(raw)) begin
      emit_beat(8'h00, 1'b1);
    end else if (raw == epd_pkg::ChBackslash) begin
      dec_mode = epd_pkg::MODE_ESCAPE;
    end else begin
      emit_beat(raw, 1'b0);
    end
  endfunction

  // Advance the decoder by one input beat; leaves its result beats in step_beats.
  function automatic void decode_step(logic [7:0] raw, logic eoi);
    step_beats.delete();
    case (dec_mode)
      epd_pkg::MODE_ESCAPE: begin
        dec_mode = epd_pkg::MODE_NORMAL;
        if (eoi) begin
          emit_beat(8'h00, 1'b0);
          decode_plain(raw, eoi);
        end else begin
          case (raw)
            epd_pkg::ChBackslash, epd_pkg::ChSpace: emit_beat(raw, 1'b0);
            epd_pkg::ChLetterN: emit_beat(epd_pkg::ChLf, 1'b0);
            epd_pkg::ChLetterR: emit_beat(epd_pkg::ChCr, 1'b0);
            epd_pkg::ChLetterT: emit_beat(epd_pkg::ChTab, 1'b0);
            epd_pkg::ChLetterB: emit_beat(epd_pkg::ChBs, 1'b0);
            epd_pkg::ChLetterF: emit_beat(epd_pkg::ChFf, 1'b0);
            epd_pkg::ChLetterV: emit_beat(epd_pkg::ChVt, 1'b0);
            default: begin
              if (is_octal(raw)) begin
                dec_mode  = epd_pkg::MODE_OCTAL;
                octal_val = raw - epd_pkg::ChZero;
                octal_cnt = 2'd1;
              end else begin
                emit_beat(8'h00, 1'b0);
                decode_plain(raw, eoi);
              end
            end
          endcase
        end
      end
      epd_pkg::MODE_OCTAL: begin
        if (!eoi && is_octal(raw)) begin
          octal_val = (octal_val << 3) + (raw - epd_pkg::ChZero);
          octal_cnt = octal_cnt + 2'd1;
          if (octal_cnt >= OctalMaxDigits) begin
            emit_beat(octal_val, 1'b0);
            dec_mode  = epd_pkg::MODE_NORMAL;
            octal_val = 8'h00;
            octal_cnt = 2'd0;
          end
        end else begin
          emit_beat(octal_val, 1'b0);
          dec_mode  = epd_pkg::MODE_NORMAL;
          octal_val = 8'h00;
          octal_cnt = 2'd0;
          decode_plain(raw, eoi);
        end
      end
      default: begin
        dec_mode = epd_pkg::MODE_NORMAL;
        decode_plain(raw, eoi);
      end
    endcase
    if (step_beats.size() != 0) step_beats[$].last = 1'b1;
  endfunction

  function automatic void add_item(logic [7:0] raw, logic eoi);
    pending_q.push_back('{raw, eoi, 1'b0, 2'd0, NoBeat, NoBeat});
  endfunction

  // Queue one random token: mostly well-formed text and escapes, some noise.
  task automatic queue_token();
    int pick;
    int reps;
    logic [7:0] raw;
    pick = $urandom_range(99);
    if (pick < 30) begin
      reps = $urandom_range(1, 4);
      repeat (reps) begin
        do raw = 8'($urandom_range(255));
        while (is_blank(raw) || raw == epd_pkg::ChBackslash);
        add_item(raw, 1'b0);
      end
    end else if (pick < 45) begin
      add_item(epd_pkg::ChBackslash, 1'b0);
      add_item(EscLetters[$urandom_range(7)], 1'b0);
    end else if (pick < 60) begin
      add_item(epd_pkg::ChBackslash, 1'b0);
      reps = $urandom_range(1, 3);
      repeat (reps) add_item(epd_pkg::ChZero + 8'($urandom_range(7)), 1'b0);
    end else if (pick < 75) begin
      if ($urandom_range(3) == 0) add_item(8'($urandom_range(255)), 1'b1);
      else if ($urandom_range(1) == 0) add_item(epd_pkg::ChSpace, 1'b0);
      else add_item(epd_pkg::ChTab + 8'($urandom_range(4)), 1'b0);
    end else if (pick < 85) begin
      add_item(epd_pkg::ChBackslash, 1'b0);
      add_item(8'($urandom_range(255)), $urandom_range(7) == 0);
    end else begin
      add_item(8'($urandom_range(255)), $urandom_range(7) == 0);
    end
  endtask

  // Drive one beat, hold until taken, then record what it should produce.
  task automatic send_beat(row_t item);
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= item.raw;
    in_ch.end_of_input <= item.eoi;
    do @(posedge clk_i); while (!in_ch.ready);
    n_items++;
    decode_step(item.raw, item.eoi);
    if (item.typed) begin
      if (item.n > 0) decoded_q.push_back(item.b0);
      if (item.n > 1) decoded_q.push_back(item.b1);
    end else begin
      foreach (step_beats[i]) decoded_q.push_back(step_beats[i]);
    end
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_beats++;
      if (out_ch.path_end) n_ends++;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat byte=%02h path_end=%0b last=%0b", $time,
                 out_ch.out_byte, out_ch.path_end, out_ch.last);
      end else begin
        want = decoded_q.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          errors++;
          $display("%0t: out_byte expected %02h got %02h", $time, want.out_byte,
                   out_ch.out_byte);
        end
        if (out_ch.path_end !== want.path_end) begin
          errors++;
          $display("%0t: path_end expected %0b got %0b", $time, want.path_end,
                   out_ch.path_end);
        end
        if (out_ch.last !== want.last) begin
          errors++;
          $display("%0t: last expected %0b got %0b", $time, want.last, out_ch.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timed out with %0d beats outstanding", $time, decoded_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int phase;
    int target;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'h00;
    in_ch.end_of_input = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) send_beat(DirRows[i]);

    // Random text: no idling, sender gaps, receiver stalls, then both
    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 55 : (phase == 3) ? 13 : 0;
      stall_pct = (phase == 2) ? 55 : (phase == 3) ? 13 : 0;
      target = n_items + PhaseItems;
      while (n_items < target) begin
        if (pending_q.size() == 0) queue_token();
        send_beat(pending_q.pop_front());
      end
      // Hold off until every result of this phase is out
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while (decoded_q.size() != 0);
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d input beats (directed table, then escaped text under four idle mixes);",
             n_items);
    $display("checked %0d result beats, %0d of them path ends.", n_beats, n_ends);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/epd_pkg.sv
rtl/epd_if.sv
rtl/epd_front.sv
rtl/epd_queue.sv
rtl/epd_back.sv
rtl/escaped_path_decoder.sv
dv/tb_escaped_path_decoder.sv
